@@ hw/rtl/nrpe_pkg.sv @@
// Shared types, character codes and helper functions for the RMC position extractor.
// No dependencies; every other file in this block imports this package.
`timescale 1ns / 1ps

package nrpe_pkg;

  localparam int unsigned LINE_LIMIT_DEF = 128;

  // ASCII codes the parser reacts to.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_N      = 8'h4E;

  localparam int unsigned HDR_LEN = 6;

  // Field numbers (commas seen so far) and digit positions inside fields.
  localparam logic [3:0] FLD_STATUS  = 4'd2;
  localparam logic [3:0] FLD_LAT     = 4'd3;
  localparam logic [3:0] FLD_LAT_DIR = 4'd4;
  localparam logic [3:0] FLD_LON     = 4'd5;
  localparam logic [3:0] FLD_LON_DIR = 4'd6;
  localparam logic [3:0] CNT_MAX     = 4'd15;
  localparam logic [3:0] LAT_DOT     = 4'd4;
  localparam logic [3:0] LAT_LAST    = 4'd8;
  localparam logic [3:0] LON_DOT     = 4'd5;
  localparam logic [3:0] LON_LAST    = 4'd9;

  localparam int unsigned DEC_W   = 20;
  localparam int unsigned MIL_W   = 21;
  localparam int unsigned TDATA_W = 80;
  localparam logic [MIL_W-1:0] MIL_MAX = 21'd1666665;

  // ceil(2^24 / 3): exact quotient by three for any 21-bit dividend.
  localparam logic [22:0] DIV3_MUL = 23'd5592406;

  typedef struct packed {
    logic        ovf;
    logic        hdr;
    logic [3:0]  commas;
    logic [7:0]  status;
    logic [3:0]  lat_off;
    logic [3:0]  lon_off;
    logic [31:0] lat_dig;
    logic [35:0] lon_dig;
    logic [8:0]  lat_dir;
    logic [8:0]  lon_dir;
    logic        fresh;
    logic        ended;
  } line_st_t;

  // One finished line, handed from the parser to the converter.
  typedef struct packed {
    logic             take;
    logic             fix;
    logic [6:0]       lat_deg;
    logic [DEC_W-1:0] lat_dec;
    logic [8:0]       lat_dir;
    logic [9:0]       lon_deg;
    logic [DEC_W-1:0] lon_dec;
    logic [8:0]       lon_dir;
  } line_rec_t;

  // Result layout: the last field declared, lon_degrees, sits in the lowest bits.
  typedef struct packed {
    logic [7:0]       lat_hemisphere;
    logic [MIL_W-1:0] lat_millionths;
    logic [6:0]       lat_degrees;
    logic [7:0]       lon_hemisphere;
    logic [MIL_W-1:0] lon_millionths;
    logic [9:0]       lon_degrees;
  } pos_t;

  localparam int unsigned PAD_W = TDATA_W - $bits(pos_t);

  localparam pos_t POS_CLEAR = '{
    lat_hemisphere: CH_N, lat_millionths: '0, lat_degrees: '0,
    lon_hemisphere: CH_E, lon_millionths: '0, lon_degrees: '0
  };

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;  // $
      3'd1:    ch = 8'h47;  // G
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h52;  // R
      3'd4:    ch = 8'h4D;  // M
      3'd5:    ch = 8'h43;  // C
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [DEC_W-1:0] div3(input logic [MIL_W-1:0] x);
    logic [43:0] prod;
    prod = 44'(x) * 44'(DIV3_MUL);
    return prod[43:24];
  endfunction

endpackage

@@ hw/rtl/nmea_rmc_position_extractor.sv @@
// A newline byte passes three registers: the input byte register at the accepting edge,
// then the line record register, then the result register.
// Throughput: one byte per cycle; a newline waits only while the result register is full.
// Reset (asynchronous, active low) empties the pipeline, clears the line state and sets
// the held position to 0 degrees with hemispheres 'N' and 'E'.
// Top level of the RMC position extractor; instantiates nrpe_parser and nrpe_convert.
`timescale 1ns / 1ps

module nmea_rmc_position_extractor import nrpe_pkg::*; #(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] rx_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [9:0] lon_degrees, [30:10] lon_millionths, [38:31] lon_hemisphere,
  // [45:39] lat_degrees, [66:46] lat_millionths, [74:67] lat_hemisphere, [79:75] zero
  output logic [TDATA_W-1:0] m_axis_tdata_o
);

  logic      rec_vld, rec_rdy;
  line_rec_t rec;
  pos_t      pos;

  nrpe_parser #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_vld_i(s_axis_tvalid_i),
    .byte_rdy_o(s_axis_tready_o),
    .byte_i    (s_axis_tdata_i),
    .rec_vld_o (rec_vld),
    .rec_rdy_i (rec_rdy),
    .rec_o     (rec)
  );

  nrpe_convert u_convert (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rec_vld_i(rec_vld),
    .rec_rdy_o(rec_rdy),
    .rec_i    (rec),
    .out_vld_o(m_axis_tvalid_o),
    .out_rdy_i(m_axis_tready_i),
    .pos_o    (pos)
  );

  assign m_axis_tdata_o = {PAD_W'(0), pos};

endmodule

@@ hw/rtl/nrpe_parser.sv @@
// Input byte register and line parser: tracks header, commas and digit fields.
// On a newline it registers a line record for the converter. Uses nrpe_pkg.
`timescale 1ns / 1ps

module nrpe_parser import nrpe_pkg::*; #(
  parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_vld_i,
  output logic       byte_rdy_o,
  input  logic [7:0] byte_i,
  output logic       rec_vld_o,
  input  logic       rec_rdy_i,
  output line_rec_t  rec_o
);

  localparam int unsigned LEN_W = $clog2(LINE_LIMIT);

  logic             b_vld_q, b_vld_d;
  logic [7:0]       b_q;
  line_st_t         st_q, st_d, st;
  logic [LEN_W-1:0] len_q, len_d, len;
  logic             rec_vld_q;
  line_rec_t        rec_q, rec_d;
  logic             is_nl, rec_free, go, digit;
  logic [3:0]       dval;
  logic [2:0]       lat_slot;
  logic [3:0]       lon_slot;

  assign is_nl      = (b_q == CH_NL);
  assign rec_free   = !rec_vld_q || rec_rdy_i;
  assign go         = b_vld_q && (!is_nl || rec_free);
  assign byte_rdy_o = !b_vld_q || go;
  assign b_vld_d    = (byte_vld_i && byte_rdy_o) || (b_vld_q && !go);

  assign digit = (b_q >= CH_ZERO) && (b_q <= CH_NINE);
  assign dval  = b_q[3:0];
  // A dollar byte is not a digit, so the slots may come from the old offsets.
  assign lat_slot = (st_q.lat_off < LAT_DOT) ? st_q.lat_off[2:0] : 3'(st_q.lat_off - 4'd1);
  assign lon_slot = (st_q.lon_off < LON_DOT) ? st_q.lon_off : (st_q.lon_off - 4'd1);

  always_comb begin
    st  = st_q;
    len = len_q;
    if (b_q == CH_DOLLAR) begin
      st  = '0;
      len = '0;
    end
    if (len >= LEN_W'(LINE_LIMIT - 1)) begin
      st.ovf = 1'b1;
    end else begin
      if (len == '0) begin
        st.hdr = (b_q == hdr_char(3'd0));
      end else if (len < LEN_W'(HDR_LEN)) begin
        st.hdr = st.hdr && (b_q == hdr_char(len[2:0]));
      end
      len = len + 1'b1;
      if (!st.ended) begin
        if (st.fresh) begin
          if (st.commas == FLD_STATUS) begin
            st.status = b_q;
          end else if (st.commas == FLD_LAT_DIR) begin
            st.lat_dir = {1'b1, b_q};
          end else if (st.commas == FLD_LON_DIR) begin
            st.lon_dir = {1'b1, b_q};
          end
        end
        st.fresh = 1'b0;
        if (st.commas == FLD_LAT) begin
          if (digit && st.lat_off <= LAT_LAST && st.lat_off != LAT_DOT) begin
            st.lat_dig[{lat_slot, 2'b00} +: 4] = st.lat_dig[{lat_slot, 2'b00} +: 4] | dval;
          end
          if (st.lat_off < CNT_MAX) st.lat_off = st.lat_off + 4'd1;
        end else if (st.commas == FLD_LON) begin
          if (digit && st.lon_off <= LON_LAST && st.lon_off != LON_DOT) begin
            st.lon_dig[{lon_slot, 2'b00} +: 4] = st.lon_dig[{lon_slot, 2'b00} +: 4] | dval;
          end
          if (st.lon_off < CNT_MAX) st.lon_off = st.lon_off + 4'd1;
        end
        if (b_q == CH_NUL) begin
          st.ended = 1'b1;
        end else if (b_q == CH_COMMA) begin
          if (st.commas < CNT_MAX) st.commas = st.commas + 4'd1;
          st.fresh = 1'b1;
        end
      end
    end

    // A newline never writes a digit, so the stored digits are final here.
    rec_d.take    = !st.ovf && st.hdr;
    rec_d.fix     = (st.status == CH_A);
    rec_d.lat_deg = 7'(st_q.lat_dig[3:0]) * 7'd10 + 7'(st_q.lat_dig[7:4]);
    rec_d.lat_dec = DEC_W'(st_q.lat_dig[11:8])  * DEC_W'(100000)
                  + DEC_W'(st_q.lat_dig[15:12]) * DEC_W'(10000)
                  + DEC_W'(st_q.lat_dig[19:16]) * DEC_W'(1000)
                  + DEC_W'(st_q.lat_dig[23:20]) * DEC_W'(100)
                  + DEC_W'(st_q.lat_dig[27:24]) * DEC_W'(10)
                  + DEC_W'(st_q.lat_dig[31:28]);
    rec_d.lat_dir = st.lat_dir;
    rec_d.lon_deg = 10'(st_q.lon_dig[3:0]) * 10'd100 + 10'(st_q.lon_dig[7:4]) * 10'd10
                  + 10'(st_q.lon_dig[11:8]);
    rec_d.lon_dec = DEC_W'(st_q.lon_dig[15:12]) * DEC_W'(100000)
                  + DEC_W'(st_q.lon_dig[19:16]) * DEC_W'(10000)
                  + DEC_W'(st_q.lon_dig[23:20]) * DEC_W'(1000)
                  + DEC_W'(st_q.lon_dig[27:24]) * DEC_W'(100)
                  + DEC_W'(st_q.lon_dig[31:28]) * DEC_W'(10)
                  + DEC_W'(st_q.lon_dig[35:32]);
    rec_d.lon_dir = st.lon_dir;

    st_d  = st;
    len_d = len;
    if (is_nl) begin
      st_d  = '0;
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      st_q      <= '0;
      len_q     <= '0;
      rec_vld_q <= 1'b0;
    end else begin
      b_vld_q <= b_vld_d;
      if (go) begin
        st_q  <= st_d;
        len_q <= len_d;
      end
      if (rec_free) begin
        rec_vld_q <= go && is_nl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_vld_i && byte_rdy_o) begin
      b_q <= byte_i;
    end
    if (rec_free && go && is_nl) begin
      rec_q <= rec_d;
    end
  end

  assign rec_vld_o = rec_vld_q;
  assign rec_o     = rec_q;

endmodule

@@ hw/rtl/nrpe_convert.sv @@
// Minutes-to-millionths conversion, held position and result register.
// Takes line records from nrpe_parser; uses nrpe_pkg.
`timescale 1ns / 1ps

module nrpe_convert import nrpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rec_vld_i,
  output logic      rec_rdy_o,
  input  line_rec_t rec_i,
  output logic      out_vld_o,
  input  logic      out_rdy_i,
  output pos_t      pos_o
);

  logic out_vld_q;
  pos_t out_q;
  pos_t held_q, held_d, fix_pos;
  logic acc;

  assign rec_rdy_o = !out_vld_q || out_rdy_i;
  assign acc       = rec_vld_i && rec_rdy_o;

  // minutes*1e6 + frac*100 over 60 equals 5*D/3 with D the six digits mmffff,
  // and floor(5D/3) = D + floor(2D/3).
  always_comb begin
    fix_pos.lat_degrees    = rec_i.lat_deg;
    fix_pos.lat_millionths = MIL_W'(rec_i.lat_dec) + MIL_W'(div3({rec_i.lat_dec, 1'b0}));
    fix_pos.lat_hemisphere = rec_i.lat_dir[8] ? rec_i.lat_dir[7:0] : CH_N;
    fix_pos.lon_degrees    = rec_i.lon_deg;
    fix_pos.lon_millionths = MIL_W'(rec_i.lon_dec) + MIL_W'(div3({rec_i.lon_dec, 1'b0}));
    fix_pos.lon_hemisphere = rec_i.lon_dir[8] ? rec_i.lon_dir[7:0] : CH_E;
    held_d = held_q;
    if (rec_i.take) begin
      held_d = rec_i.fix ? fix_pos : POS_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      held_q    <= POS_CLEAR;
    end else begin
      if (rec_rdy_o) begin
        out_vld_q <= rec_vld_i;
      end
      if (acc) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= held_d;
    end
  end

  assign out_vld_o = out_vld_q;
  assign pos_o     = out_q;

endmodule

@@ hw/rtl/nrpe_checker.sv @@
// Port-level checks for nmea_rmc_position_extractor, attached by the bind below.
// Uses nrpe_pkg for the result layout limits.
`timescale 1ns / 1ps

module nrpe_checker import nrpe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [7:0]         s_axis_tdata_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o
);

  // With an empty result register nothing downstream can stall the input.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the result register is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result item changed");

  // Conversion range: degrees from decimal digits, millionths at most 99.9999 min / 60.
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[9:0] <= 10'd999 && m_axis_tdata_o[45:39] <= 7'd99
      && m_axis_tdata_o[30:10] <= MIL_MAX && m_axis_tdata_o[66:46] <= MIL_MAX
      && m_axis_tdata_o[79:75] == '0)
    else $error("result item out of range");

endmodule

bind nmea_rmc_position_extractor nrpe_checker u_nrpe_checker (.*);

@@ bench/rmc_position_monitor.sv @@
// Scoreboard for the RMC position extractor: tracks each line byte by byte,
// predicts the position emitted on every newline and checks the result stream.
// Depends on nrpe_pkg for the result layout and character codes.
`timescale 1ns / 1ps

module rmc_position_monitor import nrpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  input  logic               rx_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               fix_valid_i,
  input  logic               fix_ready_i,
  input  logic [TDATA_W-1:0] fix_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [47:0] RMC_TAG    = "$GPRMC";
  localparam int          REPORT_MAX = 10;

  int          ln_len;
  logic        ln_over;
  logic        hdr_match;
  logic        fld_start;
  logic        txt_done;
  logic [3:0]  n_commas;
  logic [3:0]  lat_pos;
  logic [3:0]  lon_pos;
  logic [7:0]  stat_ch;
  logic [31:0] lat_nib;
  logic [35:0] lon_nib;
  logic [8:0]  lat_hemi;
  logic [8:0]  lon_hemi;
  pos_t        held_fix;
  pos_t        due_positions[$];
  int          n_fail;

  task automatic clear_line();
    ln_len    = 0;
    ln_over   = 1'b0;
    hdr_match = 1'b0;
    fld_start = 1'b0;
    txt_done  = 1'b0;
    n_commas  = '0;
    lat_pos   = '0;
    lon_pos   = '0;
    stat_ch   = '0;
    lat_nib   = '0;
    lon_nib   = '0;
    lat_hemi  = '0;
    lon_hemi  = '0;
  endtask

  task automatic parse_rx_byte(input logic [7:0] c);
    int          slot;
    int unsigned deg;
    int unsigned mins;
    int unsigned frac;
    logic        is_dig;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_DOLLAR) clear_line();
    if (ln_len >= LINE_LIMIT_DEF - 1) begin
      ln_over = 1'b1;
    end else begin
      if (ln_len == 0) begin
        hdr_match = (c == RMC_TAG[47 -: 8]);
      end else if (ln_len < HDR_LEN) begin
        hdr_match = hdr_match && (c == RMC_TAG[47 - 8 * ln_len -: 8]);
      end
      ln_len++;
      // A zero byte ends the text; everything after it is dead weight.
      if (!txt_done) begin
        if (fld_start) begin
          if (n_commas == FLD_STATUS) stat_ch = c;
          else if (n_commas == FLD_LAT_DIR) lat_hemi = {1'b1, c};
          else if (n_commas == FLD_LON_DIR) lon_hemi = {1'b1, c};
        end
        fld_start = 1'b0;
        if (n_commas == FLD_LAT) begin
          if (is_dig && lat_pos <= LAT_LAST && lat_pos != LAT_DOT) begin
            slot = (lat_pos < LAT_DOT) ? lat_pos : lat_pos - 1;
            lat_nib[4 * slot +: 4] = c[3:0];
          end
          if (lat_pos != CNT_MAX) lat_pos++;
        end else if (n_commas == FLD_LON) begin
          if (is_dig && lon_pos <= LON_LAST && lon_pos != LON_DOT) begin
            slot = (lon_pos < LON_DOT) ? lon_pos : lon_pos - 1;
            lon_nib[4 * slot +: 4] = c[3:0];
          end
          if (lon_pos != CNT_MAX) lon_pos++;
        end
        if (c == CH_NUL) begin
          txt_done = 1'b1;
        end else if (c == CH_COMMA) begin
          if (n_commas != CNT_MAX) n_commas++;
          fld_start = 1'b1;
        end
      end
    end
    if (c == CH_NL) begin
      if (!ln_over && hdr_match) begin
        if (stat_ch != CH_A) begin
          held_fix = POS_CLEAR;
        end else begin
          deg  = lat_nib[3:0] * 10 + lat_nib[7:4];
          mins = lat_nib[11:8] * 10 + lat_nib[15:12];
          frac = lat_nib[19:16] * 1000 + lat_nib[23:20] * 100
               + lat_nib[27:24] * 10 + lat_nib[31:28];
          held_fix.lat_degrees    = 7'(deg);
          held_fix.lat_millionths = 21'((mins * 1000000 + frac * 100) / 60);
          held_fix.lat_hemisphere = lat_hemi[8] ? lat_hemi[7:0] : CH_N;
          deg  = lon_nib[3:0] * 100 + lon_nib[7:4] * 10 + lon_nib[11:8];
          mins = lon_nib[15:12] * 10 + lon_nib[19:16];
          frac = lon_nib[23:20] * 1000 + lon_nib[27:24] * 100
               + lon_nib[31:28] * 10 + lon_nib[35:32];
          held_fix.lon_degrees    = 10'(deg);
          held_fix.lon_millionths = 21'((mins * 1000000 + frac * 100) / 60);
          held_fix.lon_hemisphere = lon_hemi[8] ? lon_hemi[7:0] : CH_E;
        end
      end
      due_positions.push_back(held_fix);
      clear_line();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pos_t want;
    pos_t seen;
    if (!rst_ni) begin
      clear_line();
      held_fix = POS_CLEAR;
      due_positions.delete();
      n_fail = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Results go first so that a stray result never consumes the expectation
      // of a newline accepted at the same edge.
      if (fix_valid_i && fix_ready_i) begin
        seen = fix_data_i[$bits(pos_t)-1:0];
        if (due_positions.size() == 0) begin
          n_fail++;
          if (n_fail <= REPORT_MAX) begin
            $display("%0t: position item with none expected: %h", $time, fix_data_i);
          end
        end else begin
          want = due_positions.pop_front();
          if (seen !== want || fix_data_i[TDATA_W-1:$bits(pos_t)] !== '0) begin
            n_fail++;
            if (n_fail <= REPORT_MAX) begin
              $display("%0t: position mismatch (lon deg/mil/hemi, lat deg/mil/hemi, pad)",
                       $time);
              $display("  expected %0d %0d %0d, %0d %0d %0d, 0", want.lon_degrees,
                       want.lon_millionths, want.lon_hemisphere, want.lat_degrees,
                       want.lat_millionths, want.lat_hemisphere);
              $display("  actual   %0d %0d %0d, %0d %0d %0d, %0d", seen.lon_degrees,
                       seen.lon_millionths, seen.lon_hemisphere, seen.lat_degrees,
                       seen.lat_millionths, seen.lat_hemisphere,
                       fix_data_i[TDATA_W-1:$bits(pos_t)]);
            end
          end
        end
      end
      if (rx_valid_i && rx_ready_i) parse_rx_byte(rx_byte_i);
      fail_count_o <= n_fail;
      pending_o    <= due_positions.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the RMC position extractor bench: clock, reset, NMEA byte stimulus,
// result-side backpressure and the verdict. Depends on nrpe_pkg, the block
// and rmc_position_monitor.
`timescale 1ns / 1ps

module tb_top;
  import nrpe_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         HOLD_CYCLES    = 200;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_V   = 8'h56;
  localparam logic [7:0] CH_W   = 8'h57;

  logic               clk_i;
  logic               rst_ni;
  logic               rx_valid;
  logic               rx_ready;
  logic [7:0]         rx_byte;
  logic               fix_valid;
  logic               fix_ready;
  logic [TDATA_W-1:0] fix_data;
  int                 fail_count;
  int                 pending;
  int                 src_idle_pct  = 0;
  int                 snk_stall_pct = 0;
  logic               hold_req      = 1'b0;
  int                 quiet_cycles  = 0;
  logic [7:0]         tx_bytes[$];

  nmea_rmc_position_extractor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(rx_valid),
    .s_axis_tready_o(rx_ready),
    .s_axis_tdata_i (rx_byte),
    .m_axis_tvalid_o(fix_valid),
    .m_axis_tready_i(fix_ready),
    .m_axis_tdata_o (fix_data)
  );

  rmc_position_monitor u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid),
    .rx_ready_i  (rx_ready),
    .rx_byte_i   (rx_byte),
    .fix_valid_i (fix_valid),
    .fix_ready_i (fix_ready),
    .fix_data_i  (fix_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    fix_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        fix_ready = 1'b0;
      end else begin
        fix_ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_valid && rx_ready) || (fix_valid && fix_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  task automatic end_line(input logic crlf);
    if (crlf) tx_bytes.push_back(CH_CR);
    tx_bytes.push_back(CH_NL);
  endtask

  // Any byte that leaves the line structure alone.
  function automatic logic [7:0] filler_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ch inside {CH_DOLLAR, CH_COMMA, CH_NL, CH_NUL});
    return ch;
  endfunction

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) begin
      tx_bytes.push_back(($urandom_range(19) == 0) ? filler_char()
                                                   : 8'(CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic put_coord(input int int_digits);
    if ($urandom_range(9) == 0) return;
    put_digits(($urandom_range(9) == 0) ? $urandom_range(5) : int_digits);
    tx_bytes.push_back(($urandom_range(7) == 0) ? filler_char() : CH_DOT);
    put_digits($urandom_range(8));
  endtask

  task automatic put_hemi(input logic [7:0] first, input logic [7:0] second);
    case ($urandom_range(9))
      0: ;
      1: tx_bytes.push_back(filler_char());
      2: tx_bytes.push_back(CH_NUL);
      default: tx_bytes.push_back($urandom_range(1) ? first : second);
    endcase
  endtask

  task automatic put_padded(input string body, input int total);
    put_text(body);
    repeat (total - 1 - body.len()) tx_bytes.push_back(filler_char());
    end_line(1'b0);
  endtask

  task automatic put_rmc_line();
    int base;
    int cut;
    base = tx_bytes.size();
    // A started sentence that the next '$' throws away.
    if ($urandom_range(9) == 0) put_text("$GPRMC,091500,A,47");
    case ($urandom_range(19))
      0: put_text("$GPGGA");
      1: put_text("$GPRMX");
      2: put_text("GPRMC");
      default: put_text("$GPRMC");
    endcase
    tx_bytes.push_back(CH_COMMA);
    if ($urandom_range(3) != 0) begin
      put_digits(6);
      tx_bytes.push_back(CH_DOT);
      put_digits(2);
    end
    tx_bytes.push_back(CH_COMMA);
    case ($urandom_range(9))
      0: ;
      1: tx_bytes.push_back(CH_V);
      2: tx_bytes.push_back(filler_char());
      default: tx_bytes.push_back(CH_A);
    endcase
    tx_bytes.push_back(CH_COMMA);
    put_coord(4);
    tx_bytes.push_back(CH_COMMA);
    put_hemi(CH_N, CH_S);
    tx_bytes.push_back(CH_COMMA);
    put_coord(5);
    tx_bytes.push_back(CH_COMMA);
    put_hemi(CH_E, CH_W);
    case ($urandom_range(3))
      1: put_text(",022.4,084.4,230394,003.1,W*6A");
      2: repeat ($urandom_range(1, 12)) begin
        tx_bytes.push_back(CH_COMMA);
        if ($urandom_range(1)) tx_bytes.push_back(filler_char());
      end
      3: begin
        put_text(",A*");
        put_digits(2);
      end
      default: ;
    endcase
    if ($urandom_range(14) == 0) begin
      tx_bytes.insert($urandom_range(base, tx_bytes.size() - 1), CH_NUL);
    end
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(base + 1, tx_bytes.size() - 1);
      while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
    end
    end_line($urandom_range(7) != 0);
  endtask

  task automatic put_random_lines(input int min_bytes, input int min_lines);
    int n_bytes;
    int n_lines;
    int base;
    n_bytes = 0;
    n_lines = 0;
    while (n_bytes < min_bytes || n_lines < min_lines) begin
      base = tx_bytes.size();
      case ($urandom_range(19))
        15, 16: begin
          repeat ($urandom_range(24)) tx_bytes.push_back(8'($urandom_range(255)));
          end_line(1'b0);
        end
        17: put_padded("$GPRMC,,A,1234.5678,N,12345.6789,E,",
                       $urandom_range(LINE_LIMIT_DEF - 8, LINE_LIMIT_DEF + 12));
        18: end_line(1'b0);
        default: put_rmc_line();
      endcase
      n_bytes += tx_bytes.size() - base;
      n_lines++;
    end
  endtask

  // Called and returning at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_valid = 1'b0;
      @(negedge clk_i);
    end
    rx_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk_i); while (!rx_ready);
    @(negedge clk_i);
  endtask

  task automatic send_all();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
    rx_valid = 1'b0;
  endtask

  initial begin
    rst_ni   = 1'b0;
    rx_valid = 1'b0;
    rx_byte  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Position held from reset, then well-formed and edge-case sentences.
    end_line(1'b0);
    put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
    end_line(1'b1);
    put_text("$GPRMC,235959,A,9999.9999,S,99999.9999,W,,,,,*7F");
    end_line(1'b1);
    put_text("$GPRMC,,V,4807.038,N,01131.000,E");
    end_line(1'b0);
    put_text("$GPRMC,000000,A,0000.0000,N,00000.0000,E");
    end_line(1'b0);
    put_text("$GPRMC,081836,A,3751.6500,S,14507.3600,E,000.0,360.0,130998,011.3,E*62");
    end_line(1'b1);
    put_text("$GPRMC,123");
    end_line(1'b0);
    put_text("$GPRMC,235959,A,9999.9999,S,99999.9999,W");
    end_line(1'b0);
    put_text("$GPGGA,123519,A,4807.038,N,01131.000,E");
    end_line(1'b0);
    put_text("GPRMC,,A,1234.5678,N,12345.6789,E");
    end_line(1'b0);
    put_text("$GPRMC,,A,1234.5678");
    end_line(1'b0);
    put_text("$GPRMC,,A,1x3y.5z7Q,N,0a2b3-4c5d,E");
    end_line(1'b0);
    put_text("$GPRMC,,A,4807.03812345,S,01131.00099999,W");
    end_line(1'b0);
    put_text("$GPRMC,,A,48,N,011,E");
    end_line(1'b0);
    // Zero bytes: inside a digit field, as a hemisphere and as the status.
    put_text("$GPRMC,,A,48");
    tx_bytes.push_back(CH_NUL);
    put_text("07.0381,S,01131.0001,W");
    end_line(1'b0);
    put_text("$GPRMC,,A,4807.0381,");
    tx_bytes.push_back(CH_NUL);
    put_text(",01131.0001,W");
    end_line(1'b0);
    put_text("$GPRMC,,");
    tx_bytes.push_back(CH_NUL);
    put_text(",4807.0381,N,01131.0001,E");
    end_line(1'b0);
    put_text("$GPRMC,,A,1111.1111,N,11111.1111,E$GPRMC,,A,2222.2222,S,22222.2222,W");
    end_line(1'b0);
    put_text("$GPRMC,,A,1234.5678,N,12345.6789,E,,,,,,,,,,,,,,,,,,,,,A");
    end_line(1'b0);
    // Longest line that still matches, then one byte too long.
    put_padded("$GPRMC,,A,5432.1098,S,12345.6789,W,", LINE_LIMIT_DEF - 1);
    put_padded("$GPRMC,,A,5432.1098,S,12345.6789,W,", LINE_LIMIT_DEF);
    send_all();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      put_random_lines(140, 2);
      send_all();
      if (ph == 0) begin
        // Back-to-back newlines against a held-off result side fill the block.
        @(posedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
        repeat (40) end_line(1'b0);
        send_all();
      end
    end

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/nrpe_pkg.sv
hw/rtl/nrpe_parser.sv
hw/rtl/nrpe_convert.sv
hw/rtl/nmea_rmc_position_extractor.sv
hw/rtl/nrpe_checker.sv
bench/rmc_position_monitor.sv
bench/tb_top.sv
